// ===== hdl/kcmq_pkg.sv =====
package kcmq_pkg;

    localparam int CAPACITY  = 256;
    localparam int KEY_BITS  = 16;
    localparam int COUNT_BITS = 32;
    localparam int TOTAL_W   = $clog2(CAPACITY + 1);

    typedef logic [2*KEY_BITS-1:0]          t_key;
    typedef logic signed [COUNT_BITS-1:0]   t_cnt;

    typedef struct packed {
        logic vld;
        t_key key;
        t_cnt cnt;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_MATCH,
        CELL_REMOVE,
        CELL_INSERT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_key     key;
        t_cnt     cnt;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        KIND_PUSH  = 3'd0,
        KIND_ERASE = 3'd1,
        KIND_POP   = 3'd2,
        KIND_INC   = 3'd3,
        KIND_DEC   = 3'd4,
        KIND_ADD   = 3'd5,
        KIND_SUB   = 3'd6,
        KIND_QUERY = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ABSENT  = 3'd1,
        ST_PRESENT = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    // priority of (ka,ca) strictly above (kb,cb): larger count, then smaller key
    function automatic logic prio_gt(t_key ka, t_cnt ca, t_key kb, t_cnt cb);
        return (ca > cb) || ((ca == cb) && (ka < kb));
    endfunction

endpackage

// ===== hdl/kcmq_cell.sv =====
module kcmq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kcmq_pkg::t_cell_ctrl i_ctrl,
    input  kcmq_pkg::t_entry    i_left,
    input  logic                i_left_beats,
    input  kcmq_pkg::t_entry    i_right,
    output kcmq_pkg::t_entry    o_ent,
    output logic                o_beats,
    output logic                o_match
);
    import kcmq_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    logic   r_match;
    logic   n_match;
    logic   take_right;

    assign o_beats = r_ent.vld && prio_gt(r_ent.key, r_ent.cnt, i_ctrl.key, i_ctrl.cnt);
    assign take_right = !r_ent.vld || (r_ent.key == i_ctrl.key)
                        || prio_gt(i_ctrl.key, i_ctrl.cnt, r_ent.key, r_ent.cnt);

    always_comb begin
        n_ent   = r_ent;
        n_match = r_match;
        unique case (i_ctrl.op)
            CELL_HOLD: ;
            CELL_MATCH: begin
                n_match = r_ent.vld && (r_ent.key == i_ctrl.key);
            end
            CELL_REMOVE: begin
                // close the gap: everything at or below the removed entry moves up
                if (take_right) begin
                    n_ent = i_right;
                end
            end
            CELL_INSERT: begin
                if (!o_beats) begin
                    if (i_left_beats) begin
                        n_ent.vld = 1'b1;
                        n_ent.key = i_ctrl.key;
                        n_ent.cnt = i_ctrl.cnt;
                    end else begin
                        n_ent = i_left;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.vld <= 1'b0;
            r_match   <= 1'b0;
        end else begin
            r_ent.vld <= n_ent.vld;
            r_match   <= n_match;
        end
        r_ent.key <= n_ent.key;
        r_ent.cnt <= n_ent.cnt;
    end

    assign o_ent   = r_ent;
    assign o_match = r_match;

endmodule

// ===== hdl/keyed_count_max_queue_unit.sv =====
// Each item passes through the states match, find (reduce), remove, insert and then
// result, one item in flight at a time; o_stall holds off the next item until the
// result has been taken and the unit is back in idle, longer while the result stalls.
// The sorted cell row keeps the top entry in cell 0; the match
// reduction over all cells and the separate remove and insert shifts each have their
// own state. Synchronous active-low reset empties the row at once.
module keyed_count_max_queue_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [2:0]                     i_kind,
    input  logic [kcmq_pkg::KEY_BITS-1:0]  i_key_first,
    input  logic [kcmq_pkg::KEY_BITS-1:0]  i_key_second,
    input  logic signed [kcmq_pkg::COUNT_BITS-1:0] i_amount,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [2:0]                     o_status,
    output logic                           o_key_present,
    output logic signed [kcmq_pkg::COUNT_BITS-1:0] o_key_count,
    output logic [kcmq_pkg::KEY_BITS-1:0]  o_top_first,
    output logic [kcmq_pkg::KEY_BITS-1:0]  o_top_second,
    output logic signed [kcmq_pkg::COUNT_BITS-1:0] o_top_count,
    output logic                           o_is_empty
);
    import kcmq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MATCH, S_FIND, S_REMOVE, S_INSERT, S_OUT
    } t_state;

    localparam t_cnt CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam t_cnt CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    t_state         r_state;
    t_kind          r_kind;
    t_key           r_key;
    t_cnt           r_amt;
    logic           r_found;
    t_cnt           r_old;
    logic           r_ins;
    t_cnt           r_newcnt;
    t_status        r_status;
    logic           r_present;
    t_cnt           r_kcount;
    logic [TOTAL_W-1:0] r_total;

    t_cell_ctrl     ctrl;
    t_entry         ent   [CAPACITY];
    logic           beats [CAPACITY];
    logic           match [CAPACITY];
    logic           found;
    t_cnt           old_cnt;

    // decision, valid in S_REMOVE
    logic           d_rm;
    logic           d_ins;
    t_cnt           d_newcnt;
    t_status        d_status;
    logic           d_present;
    t_cnt           d_kcount;
    logic           full;
    t_cnt           delta;
    logic signed [COUNT_BITS:0] sum;
    t_cnt           sat_sum;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_entry left_e;
            t_entry right_e;
            logic   left_b;
            if (gi == 0) begin : g_first
                assign left_e = '0;
                assign left_b = 1'b1;
            end else begin : g_mid
                assign left_e = ent[gi-1];
                assign left_b = beats[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_e = '0;
            end else begin : g_inner
                assign right_e = ent[gi+1];
            end
            kcmq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_left       (left_e),
                .i_left_beats (left_b),
                .i_right      (right_e),
                .o_ent        (ent[gi]),
                .o_beats      (beats[gi]),
                .o_match      (match[gi])
            );
        end
    endgenerate

    always_comb begin
        found   = 1'b0;
        old_cnt = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            found   = found | match[i];
            old_cnt = old_cnt | (match[i] ? ent[i].cnt : '0);
        end
    end

    assign full  = (r_total == TOTAL_W'(CAPACITY));
    assign delta = (r_kind == KIND_INC || r_kind == KIND_DEC) ? t_cnt'(1) : r_amt;
    assign sum   = (r_kind == KIND_DEC || r_kind == KIND_SUB)
                   ? ({r_old[COUNT_BITS-1], r_old} - {delta[COUNT_BITS-1], delta})
                   : ({r_old[COUNT_BITS-1], r_old} + {delta[COUNT_BITS-1], delta});

    always_comb begin
        if (sum > $signed({CNT_MAX[COUNT_BITS-1], CNT_MAX})) begin
            sat_sum = CNT_MAX;
        end else if (sum < $signed({CNT_MIN[COUNT_BITS-1], CNT_MIN})) begin
            sat_sum = CNT_MIN;
        end else begin
            sat_sum = sum[COUNT_BITS-1:0];
        end
    end

    always_comb begin
        d_rm      = 1'b0;
        d_ins     = 1'b0;
        d_newcnt  = delta;
        d_status  = ST_OK;
        d_present = r_found;
        d_kcount  = r_found ? r_old : '0;
        unique case (r_kind)
            KIND_PUSH: begin
                if (r_found) begin
                    d_status = ST_PRESENT;
                end else if (full) begin
                    d_status = ST_FULL;
                end else begin
                    d_ins     = 1'b1;
                    d_present = 1'b1;
                    d_kcount  = r_amt;
                end
            end
            KIND_ERASE: begin
                if (!r_found) begin
                    d_status = ST_ABSENT;
                end else begin
                    d_rm = 1'b1;
                end
                d_present = 1'b0;
                d_kcount  = '0;
            end
            KIND_POP: begin
                if (r_total == '0) begin
                    d_status = ST_EMPTY;
                end else begin
                    d_rm = 1'b1;
                    if (ent[0].key == r_key) begin
                        d_present = 1'b0;
                        d_kcount  = '0;
                    end
                end
            end
            KIND_INC, KIND_ADD: begin
                if (r_found) begin
                    d_rm      = 1'b1;
                    d_ins     = 1'b1;
                    d_newcnt  = sat_sum;
                    d_kcount  = sat_sum;
                end else if (full) begin
                    d_status = ST_FULL;
                end else begin
                    d_ins     = 1'b1;
                    d_present = 1'b1;
                    d_kcount  = delta;
                end
            end
            KIND_DEC, KIND_SUB: begin
                if (!r_found) begin
                    d_status = ST_ABSENT;
                end else begin
                    d_rm     = 1'b1;
                    d_newcnt = sat_sum;
                    if (sat_sum > 0) begin
                        d_ins    = 1'b1;
                        d_kcount = sat_sum;
                    end else begin
                        d_present = 1'b0;
                        d_kcount  = '0;
                    end
                end
            end
            KIND_QUERY: ;
            default: ;
        endcase
    end

    always_comb begin
        ctrl.op  = CELL_HOLD;
        ctrl.key = r_key;
        ctrl.cnt = r_old;
        unique case (r_state)
            S_MATCH: ctrl.op = CELL_MATCH;
            S_REMOVE: begin
                if (d_rm) begin
                    ctrl.op = CELL_REMOVE;
                end
                if (r_kind == KIND_POP) begin
                    ctrl.key = ent[0].key;
                    ctrl.cnt = ent[0].cnt;
                end
            end
            S_INSERT: begin
                if (r_ins) begin
                    ctrl.op = CELL_INSERT;
                end
                ctrl.cnt = r_newcnt;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH:  r_state <= S_FIND;
                S_FIND:   r_state <= S_REMOVE;
                S_REMOVE: begin
                    r_state <= S_INSERT;
                    r_total <= r_total - TOTAL_W'(d_rm) + TOTAL_W'(d_ins);
                end
                S_INSERT: r_state <= S_OUT;
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (r_state == S_IDLE) begin
            r_kind <= t_kind'(i_kind);
            r_key  <= {i_key_first, i_key_second};
            r_amt  <= i_amount;
        end
        if (r_state == S_FIND) begin
            r_found <= found;
            r_old   <= old_cnt;
        end
        if (r_state == S_REMOVE) begin
            r_ins     <= d_ins;
            r_newcnt  <= d_newcnt;
            r_status  <= d_status;
            r_present <= d_present;
            r_kcount  <= d_kcount;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_status      = r_status;
    assign o_key_present = r_present;
    assign o_key_count   = r_kcount;
    assign o_top_first   = ent[0].vld ? ent[0].key[2*KEY_BITS-1:KEY_BITS] : '0;
    assign o_top_second  = ent[0].vld ? ent[0].key[KEY_BITS-1:0] : '0;
    assign o_top_count   = ent[0].vld ? ent[0].cnt : '0;
    assign o_is_empty    = !ent[0].vld;

endmodule

// ===== dv/tb_keyed_count_max_queue_unit.sv =====
module tb_keyed_count_max_queue_unit;
    import kcmq_pkg::*;

    localparam int CAP = CAPACITY;
    localparam int N_RANDOM = 230;

    typedef struct {
        t_kind             kind;
        logic [15:0]       kf;
        logic [15:0]       ks;
        logic signed [31:0] amt;
    } t_op_item;

    typedef struct {
        t_status           status;
        logic              present;
        logic signed [31:0] kcnt;
        logic [15:0]       tf;
        logic [15:0]       ts;
        logic signed [31:0] tcnt;
        logic              empty;
    } t_op_result;

    typedef struct {
        t_op_item   item;
        bit         has_result;
        t_op_result result;
    } t_stim_row;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    logic [2:0] i_kind = '0;
    logic [15:0] i_key_first = '0;
    logic [15:0] i_key_second = '0;
    logic signed [31:0] i_amount = '0;
    logic o_valid;
    logic i_stall = 0;
    logic [2:0] o_status;
    logic o_key_present;
    logic signed [31:0] o_key_count;
    logic [15:0] o_top_first;
    logic [15:0] o_top_second;
    logic signed [31:0] o_top_count;
    logic o_is_empty;

    keyed_count_max_queue_unit u_top (.*);

    always #4 i_clk = ~i_clk;

    // shadow of the queue contents
    bit              shadow_vld [CAP];
    logic [31:0]     shadow_key [CAP];
    logic signed [63:0] shadow_cnt [CAP];
    int              shadow_total;

    t_op_result pending_results[$];
    t_op_result typed_results[$];
    bit         typed_flags[$];
    int  mismatch_count = 0;
    bit  failed = 0;
    bit  hold_off = 0;
    bit  calm = 0;

    function automatic logic signed [63:0] clamp_count(logic signed [63:0] v);
        if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
        if (v < -64'sh80000000) return -64'sh80000000;
        return v;
    endfunction

    function automatic int lookup_key(logic [31:0] k);
        for (int i = 0; i < CAP; i++)
            if (shadow_vld[i] && shadow_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int find_leader();
        int best;
        best = -1;
        for (int i = 0; i < CAP; i++) begin
            if (!shadow_vld[i]) continue;
            if (best < 0 || shadow_cnt[i] > shadow_cnt[best] ||
                (shadow_cnt[i] == shadow_cnt[best] && shadow_key[i] < shadow_key[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic bit add_entry(logic [31:0] k, logic signed [63:0] c);
        for (int i = 0; i < CAP; i++) begin
            if (!shadow_vld[i]) begin
                shadow_vld[i] = 1;
                shadow_key[i] = k;
                shadow_cnt[i] = c;
                shadow_total++;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic void drop_entry(int i);
        shadow_vld[i] = 0;
        shadow_total--;
    endfunction

    function automatic t_op_result apply_op(t_op_item it);
        t_op_result r;
        logic [31:0] k;
        logic signed [63:0] d;
        int idx;
        int lead;
        k = {it.kf, it.ks};
        r.status = ST_OK;
        idx = lookup_key(k);
        case (it.kind)
            KIND_PUSH: begin
                if (idx >= 0) r.status = ST_PRESENT;
                else if (!add_entry(k, it.amt)) r.status = ST_FULL;
            end
            KIND_ERASE: begin
                if (idx < 0) r.status = ST_ABSENT;
                else drop_entry(idx);
            end
            KIND_POP: begin
                lead = find_leader();
                if (lead < 0) r.status = ST_EMPTY;
                else drop_entry(lead);
            end
            KIND_INC, KIND_ADD: begin
                d = (it.kind == KIND_INC) ? 64'sd1 : 64'(it.amt);
                if (idx < 0) begin
                    if (!add_entry(k, clamp_count(d))) r.status = ST_FULL;
                end else begin
                    shadow_cnt[idx] = clamp_count(shadow_cnt[idx] + d);
                end
            end
            KIND_DEC, KIND_SUB: begin
                d = (it.kind == KIND_DEC) ? 64'sd1 : 64'(it.amt);
                if (idx < 0) r.status = ST_ABSENT;
                else begin
                    shadow_cnt[idx] = clamp_count(shadow_cnt[idx] - d);
                    if (shadow_cnt[idx] <= 0) drop_entry(idx);
                end
            end
            default: ;
        endcase
        idx = lookup_key(k);
        lead = find_leader();
        r.present = (idx >= 0);
        r.kcnt = (idx >= 0) ? 32'(shadow_cnt[idx]) : '0;
        r.tf = (lead >= 0) ? shadow_key[lead][31:16] : '0;
        r.ts = (lead >= 0) ? shadow_key[lead][15:0] : '0;
        r.tcnt = (lead >= 0) ? 32'(shadow_cnt[lead]) : '0;
        r.empty = (lead < 0);
        return r;
    endfunction

    function automatic t_op_item make_op(t_kind k, logic [15:0] f, logic [15:0] s,
                                         logic signed [31:0] a);
        t_op_item it;
        it.kind = k;
        it.kf = f;
        it.ks = s;
        it.amt = a;
        return it;
    endfunction

    function automatic t_op_result make_res(t_status st, logic p, logic signed [31:0] kc,
                                            logic [15:0] f, logic [15:0] s,
                                            logic signed [31:0] tc, logic e);
        t_op_result r;
        r.status = st;
        r.present = p;
        r.kcnt = kc;
        r.tf = f;
        r.ts = s;
        r.tcnt = tc;
        r.empty = e;
        return r;
    endfunction

    function automatic void note_mismatch(string what, longint exp_v, longint act_v);
        failed = 1;
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0d got %0d", what, exp_v, act_v);
    endfunction

    // valid stays up after a transfer until the next item or release_input
    task automatic send_item(t_op_item it, bit has_typed, t_op_result typed);
        t_op_result r;
        r = apply_op(it);
        pending_results.push_back(r);
        typed_flags.push_back(has_typed);
        typed_results.push_back(typed);
        while (!calm && $urandom_range(99) < 21) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_kind <= it.kind;
        i_key_first <= it.kf;
        i_key_second <= it.ks;
        i_amount <= it.amt;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic release_input();
        i_valid <= 0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // receiver
    always @(posedge i_clk) begin
        t_op_result e;
        t_op_result t;
        bit ht;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                failed = 1;
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result transfer");
            end else begin
                e = pending_results.pop_front();
                t = typed_results.pop_front();
                ht = typed_flags.pop_front();
                if (ht) e = t;
                if (o_status !== e.status) note_mismatch("status", e.status, o_status);
                if (o_key_present !== e.present)
                    note_mismatch("key_present", e.present, o_key_present);
                if (o_key_count !== e.kcnt) note_mismatch("key_count", e.kcnt, o_key_count);
                if (o_top_first !== e.tf) note_mismatch("top_first", e.tf, o_top_first);
                if (o_top_second !== e.ts) note_mismatch("top_second", e.ts, o_top_second);
                if (o_top_count !== e.tcnt) note_mismatch("top_count", e.tcnt, o_top_count);
                if (o_is_empty !== e.empty) note_mismatch("is_empty", e.empty, o_is_empty);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off) i_stall <= 1;
        else if (calm) i_stall <= 0;
        else i_stall <= ($urandom_range(99) < 21);
    end

    function automatic logic signed [31:0] rand_amount();
        case ($urandom_range(5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(20))) - 5;
            3: return $urandom();
            default: return $signed(32'($urandom_range(1000)));
        endcase
    endfunction

    t_stim_row directed_rows[$];

    initial begin
        t_op_item it;
        t_op_result none;
        logic [15:0] f;
        logic [15:0] s;
        none = make_res(ST_OK, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < CAP; i++) begin
            shadow_vld[i] = 0;
            shadow_key[i] = '0;
            shadow_cnt[i] = 0;
        end
        shadow_total = 0;

        directed_rows.push_back('{make_op(KIND_POP, 16'h1, 16'h2, 0), 1,
                                  make_res(ST_EMPTY, 0, 0, 0, 0, 0, 1)});
        directed_rows.push_back('{make_op(KIND_QUERY, 16'h0, 16'h0, 0), 1,
                                  make_res(ST_OK, 0, 0, 0, 0, 0, 1)});
        directed_rows.push_back('{make_op(KIND_ERASE, 16'h5, 16'h5, 0), 1,
                                  make_res(ST_ABSENT, 0, 0, 0, 0, 0, 1)});
        directed_rows.push_back('{make_op(KIND_DEC, 16'h5, 16'h5, 0), 1,
                                  make_res(ST_ABSENT, 0, 0, 0, 0, 0, 1)});
        directed_rows.push_back('{make_op(KIND_SUB, 16'h5, 16'h5, 7), 1,
                                  make_res(ST_ABSENT, 0, 0, 0, 0, 0, 1)});
        directed_rows.push_back('{make_op(KIND_PUSH, 16'hFFFF, 16'hFFFF, 32'sh7FFFFFFF), 1,
                  make_res(ST_OK, 1, 32'sh7FFFFFFF, 16'hFFFF, 16'hFFFF, 32'sh7FFFFFFF, 0)});
        directed_rows.push_back('{make_op(KIND_PUSH, 16'hFFFF, 16'hFFFF, 3), 1,
                  make_res(ST_PRESENT, 1, 32'sh7FFFFFFF, 16'hFFFF, 16'hFFFF, 32'sh7FFFFFFF, 0)});
        directed_rows.push_back('{make_op(KIND_INC, 16'hFFFF, 16'hFFFF, 0), 0, none});
        directed_rows.push_back('{make_op(KIND_ADD, 16'hFFFF, 16'hFFFF, 32'sh7FFFFFFF), 0, none});
        directed_rows.push_back('{make_op(KIND_PUSH, 16'h0, 16'h0, 32'sh7FFFFFFF), 0, none});
        directed_rows.push_back('{make_op(KIND_PUSH, 16'h0, 16'h1, 32'sh80000000), 0, none});
        directed_rows.push_back('{make_op(KIND_PUSH, 16'h0, 16'h2, 0), 0, none});
        directed_rows.push_back('{make_op(KIND_ADD, 16'h0, 16'h1, 32'sh80000000), 0, none});
        directed_rows.push_back('{make_op(KIND_SUB, 16'h0, 16'h1, 32'sh7FFFFFFF), 0, none});
        directed_rows.push_back('{make_op(KIND_ADD, 16'h7, 16'h7, -5), 0, none});
        directed_rows.push_back('{make_op(KIND_INC, 16'h8, 16'h8, 0), 0, none});
        directed_rows.push_back('{make_op(KIND_DEC, 16'h8, 16'h8, 0), 0, none});
        directed_rows.push_back('{make_op(KIND_SUB, 16'h0, 16'h0, 32'sh80000000), 0, none});
        directed_rows.push_back('{make_op(KIND_POP, 16'h3, 16'h4, 0), 0, none});
        directed_rows.push_back('{make_op(KIND_POP, 16'h3, 16'h4, 0), 0, none});
        directed_rows.push_back('{make_op(KIND_ERASE, 16'h0, 16'h2, 0), 0, none});
        directed_rows.push_back('{make_op(KIND_QUERY, 16'h7, 16'h7, 0), 0, none});

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].has_result,
                      directed_rows[i].result);

        // fill the table to capacity, then hit full inserts
        for (int i = 0; shadow_total < CAP; i++)
            send_item(make_op(KIND_PUSH, 16'h100, 16'(i), rand_amount()), 0, none);
        send_item(make_op(KIND_PUSH, 16'h200, 16'h0, 1), 0, none);
        send_item(make_op(KIND_INC, 16'h200, 16'h1, 0), 0, none);
        send_item(make_op(KIND_ADD, 16'h200, 16'h2, 9), 0, none);
        for (int i = 0; i < 40 && shadow_total > 0; i++)
            send_item(make_op(KIND_POP, 16'($urandom()), 16'($urandom()), 0), 0, none);

        // sender pause until everything drains
        release_input();
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 100) calm = 1;
            if (n == 200) calm = 0;
            if (n == 210) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (60) @(negedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            if ($urandom_range(9) < 8) begin
                f = 16'($urandom_range(3));
                s = 16'($urandom_range(7));
            end else begin
                f = $urandom();
                s = $urandom();
            end
            it = make_op(t_kind'($urandom_range(7)), f, s, rand_amount());
            send_item(it, 0, none);
        end

        release_input();
        wait_drained();
        repeat (20) @(negedge i_clk);
        if (!failed) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
